// File: src/led_strip_wave_pattern_generator_core_defines.svh
// ----------------------------------------------------------------------------
// LED strip wave pattern generator - assertion macros
// Shared concurrent assertion helpers for the generator RTL.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_WAVE_PATTERN_GENERATOR_CORE_DEFINES_SVH
`define LED_STRIP_WAVE_PATTERN_GENERATOR_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define LSWPG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle is followed by a consequence in the next
`define LSWPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    `LSWPG_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

// File: src/lswpg_pkg.sv
// ----------------------------------------------------------------------------
// lswpg_pkg
// Types, register map, mode codes and the sine table of the pattern generator.
// ----------------------------------------------------------------------------
package lswpg_pkg;

    // Strip size default
    localparam int LED_COUNT_DEF = 16;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_COLOUR_A   = 3'd1;
    localparam logic [2:0] REG_COLOUR_B   = 3'd2;
    localparam logic [2:0] REG_BRIGHTNESS = 3'd3;
    localparam logic [2:0] REG_REVERSE    = 3'd4;

    // Register reset values
    localparam logic [3:0]  MODE_RST       = 4'd0;
    localparam logic [23:0] COLOUR_A_RST   = 24'hFFFFFF;
    localparam logic [23:0] COLOUR_B_RST   = 24'h000000;
    localparam logic [6:0]  BRIGHTNESS_RST = 7'd100;

    // Animation modes
    localparam logic [3:0] MODE_SOLID    = 4'd0;
    localparam logic [3:0] MODE_PULSE    = 4'd1;
    localparam logic [3:0] MODE_FADE     = 4'd2;
    localparam logic [3:0] MODE_CIRCLE   = 4'd3;
    localparam logic [3:0] MODE_CIRCLE2  = 4'd4;
    localparam logic [3:0] MODE_RB_SOLID = 4'd5;
    localparam logic [3:0] MODE_RB_WAVE  = 4'd6;
    localparam logic [3:0] MODE_RB_MUL_A = 4'd7;
    localparam logic [3:0] MODE_RB_MUL_B = 4'd8;

    // Angle arithmetic in degrees
    localparam logic [9:0] DEG_FULL   = 10'd360;
    localparam logic [9:0] PHASE_STEP = 10'd5;
    localparam logic [4:0] LED_STEP   = 5'd24;
    localparam logic [9:0] RB_OFFSET  = 10'd120;

    // Brightness percent and divide-by-100 reciprocal (exact below 43690)
    localparam logic [6:0]  BRIGHT_MAX   = 7'd100;
    localparam logic [6:0]  BRIGHT_WRAP  = 7'd101;
    localparam logic [15:0] DIV100_MUL   = 16'd41944;
    localparam int          DIV100_SHIFT = 22;

    // Sine weight midpoint
    localparam logic [16:0] SINE_MID  = 17'd32768;
    localparam logic [16:0] SINE_FULL = 17'd65536;

    // Quarter-wave sine, unsigned Q0.15, 0..90 degrees
    localparam logic [14:0] QSINE [91] = '{
        15'd0, 15'd572, 15'd1144, 15'd1715, 15'd2286, 15'd2856, 15'd3425, 15'd3993,
        15'd4560, 15'd5126, 15'd5690, 15'd6252, 15'd6813, 15'd7371, 15'd7927,
        15'd8481, 15'd9032, 15'd9580, 15'd10126, 15'd10668, 15'd11207, 15'd11743,
        15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14364, 15'd14876, 15'd15383,
        15'd15886, 15'd16384, 15'd16876, 15'd17364, 15'd17846, 15'd18323, 15'd18794,
        15'd19260, 15'd19720, 15'd20173, 15'd20621, 15'd21062, 15'd21497, 15'd21925,
        15'd22347, 15'd22762, 15'd23170, 15'd23571, 15'd23964, 15'd24351, 15'd24730,
        15'd25101, 15'd25465, 15'd25821, 15'd26169, 15'd26509, 15'd26841, 15'd27165,
        15'd27481, 15'd27788, 15'd28087, 15'd28377, 15'd28659, 15'd28932, 15'd29196,
        15'd29451, 15'd29697, 15'd29934, 15'd30162, 15'd30381, 15'd30591, 15'd30791,
        15'd30982, 15'd31163, 15'd31335, 15'd31498, 15'd31650, 15'd31794, 15'd31927,
        15'd32051, 15'd32165, 15'd32269, 15'd32364, 15'd32448, 15'd32523, 15'd32587,
        15'd32642, 15'd32687, 15'd32722, 15'd32747, 15'd32762, 15'd32767
    };

    // Configuration seen by the datapath
    typedef struct packed {
        logic [3:0]  mode;
        logic [23:0] colour_a;
        logic [23:0] colour_b;
        logic [6:0]  brightness;
        logic        reverse;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // start a frame from the current phase
        logic push;       // load the result register
        logic advance;    // move to the next LED
        logic phase_upd;  // frame done, move the phase
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic slot_free;  // result register empty or being drained
        logic last;       // current LED is the final one
    } dp_status_t;

    // Sine weight 32768 + s(deg), deg in 0..359, result in 1..65535
    function automatic logic [15:0] sine_weight(input logic [8:0] deg);
        logic [9:0]  d;
        logic [9:0]  idx;
        logic        neg;
        logic [16:0] q;
        logic [16:0] w;
        d = {1'b0, deg};
        if (d <= 10'd90) begin
            idx = d;
            neg = 1'b0;
        end else if (d <= 10'd180) begin
            idx = 10'd180 - d;
            neg = 1'b0;
        end else if (d <= 10'd270) begin
            idx = d - 10'd180;
            neg = 1'b1;
        end else begin
            idx = DEG_FULL - d;
            neg = 1'b1;
        end
        q = {2'b0, QSINE[idx[6:0]]};
        w = neg ? (SINE_MID - q) : (SINE_MID + q);
        return w[15:0];
    endfunction

    // Per-LED angle increment for one channel
    function automatic logic [4:0] mode_step(input logic [3:0] mode, input logic [1:0] k);
        logic [4:0] s;
        s = 5'd0;
        case (mode) inside
            MODE_CIRCLE, MODE_CIRCLE2, MODE_RB_WAVE: s = LED_STEP;
            MODE_RB_MUL_A: s = (k == 2'd0) ? 5'd6 : ((k == 2'd1) ? 5'd0 : LED_STEP);
            MODE_RB_MUL_B: s = (k == 2'd0) ? 5'd2 : ((k == 2'd1) ? 5'd6 : 5'd0);
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Starting angle offset for one channel
    function automatic logic [9:0] mode_offset(input logic [3:0] mode, input logic [1:0] k);
        logic [9:0] o;
        o = 10'd0;
        case (mode) inside
            MODE_RB_SOLID, MODE_RB_WAVE: o = (k == 2'd0) ? 10'd0
                                           : ((k == 2'd1) ? RB_OFFSET : 10'(RB_OFFSET * 2));
            default: o = 10'd0;
        endcase
        return o;
    endfunction

endpackage

// File: src/lswpg_ctrl.sv
// ----------------------------------------------------------------------------
// lswpg_ctrl
// Frame sequencer: takes a tick request, then walks the LEDs through the
// datapath stages and hands each result to the output register.
// ----------------------------------------------------------------------------
module lswpg_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lswpg_pkg::dp_status_t  st,
    output lswpg_pkg::ctrl_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_W1   = 3'd1;
    localparam logic [2:0] S_W2   = 3'd2;
    localparam logic [2:0] S_W3   = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Decode commands from the state
    always_comb begin
        s_tready      = (state_reg == S_IDLE);
        cmd.load      = (state_reg == S_IDLE) && s_tvalid;
        cmd.push      = (state_reg == S_PUSH) && st.slot_free;
        cmd.advance   = cmd.push && !st.last;
        cmd.phase_upd = cmd.push && st.last;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_W1;
            end
            S_W1: state_next = S_W2;
            S_W2: state_next = S_W3;
            S_W3: state_next = S_PUSH;
            S_PUSH: begin
                if (st.slot_free) state_next = st.last ? S_IDLE : S_W1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/lswpg_datapath.sv
// ----------------------------------------------------------------------------
// lswpg_datapath
// Phase and angle registers, sine lookup, colour mix, brightness scaling and
// the result register, three colour lanes side by side.
// ----------------------------------------------------------------------------
`include "led_strip_wave_pattern_generator_core_defines.svh"

module lswpg_datapath #(
    parameter int LED_COUNT = lswpg_pkg::LED_COUNT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lswpg_pkg::cfg_t        cfg,
    input  lswpg_pkg::ctrl_cmd_t   cmd,
    output lswpg_pkg::dp_status_t  st,
    input  logic                   s_step,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [5:0]             m_led_index,
    output logic [7:0]             m_red,
    output logic [7:0]             m_green,
    output logic [7:0]             m_blue,
    output logic                   m_last
);

    localparam logic [5:0] LED_LAST = 6'(LED_COUNT - 1);

    logic [8:0]  phase_reg;
    logic [8:0]  phase_next;
    logic        step_reg;
    logic [5:0]  led_idx_reg;
    logic [8:0]  ang_reg  [3];
    logic [8:0]  ang_next [3];
    logic [15:0] w_reg    [3];
    logic [15:0] w_next   [3];
    logic [23:0] pa_reg   [3];
    logic [23:0] pa_next  [3];
    logic [23:0] pb_reg   [3];
    logic [23:0] pb_next  [3];
    logic [14:0] sc_reg   [3];
    logic [14:0] sc_next  [3];
    logic [7:0]  q_next   [3];
    logic [6:0]  bval;
    logic        is_mix;
    logic        is_chan;
    logic        is_rainbow;
    logic        out_valid_reg;
    logic [5:0]  out_idx_reg;
    logic [7:0]  out_chan_reg [3];
    logic        out_last_reg;

    // Effective brightness, wrapped above 100
    assign bval = (cfg.brightness > lswpg_pkg::BRIGHT_MAX)
                  ? (cfg.brightness - lswpg_pkg::BRIGHT_WRAP) : cfg.brightness;

    // Mode class
    always_comb begin
        is_mix     = 1'b0;
        is_chan    = 1'b0;
        is_rainbow = 1'b0;
        case (cfg.mode) inside
            lswpg_pkg::MODE_FADE, lswpg_pkg::MODE_CIRCLE2: is_mix = 1'b1;
            lswpg_pkg::MODE_PULSE, lswpg_pkg::MODE_CIRCLE: is_chan = 1'b1;
            lswpg_pkg::MODE_RB_SOLID, lswpg_pkg::MODE_RB_WAVE,
            lswpg_pkg::MODE_RB_MUL_A, lswpg_pkg::MODE_RB_MUL_B: is_rainbow = 1'b1;
            default: is_mix = 1'b0;
        endcase
    end

    // Lane arithmetic: angle, sine weight, products, brightness, divide by 100
    always_comb begin
        logic [9:0]  a_sum;
        logic [7:0]  ca;
        logic [7:0]  cb;
        logic [7:0]  mx;
        logic [16:0] inv;
        logic [24:0] prod_a;
        logic [24:0] prod_b;
        logic [24:0] sum;
        logic [30:0] qprod;
        for (int k = 0; k < 3; k++) begin
            // Start of frame or next LED
            if (cmd.load) begin
                a_sum = {1'b0, phase_reg} + lswpg_pkg::mode_offset(cfg.mode, 2'(k));
            end else begin
                a_sum = {1'b0, ang_reg[k]}
                        + {5'b0, lswpg_pkg::mode_step(cfg.mode, 2'(k))};
            end
            if (a_sum >= lswpg_pkg::DEG_FULL) a_sum = a_sum - lswpg_pkg::DEG_FULL;
            ang_next[k] = a_sum[8:0];

            w_next[k] = lswpg_pkg::sine_weight(ang_reg[k]);

            ca  = cfg.colour_a[16 - 8 * k +: 8];
            cb  = cfg.colour_b[16 - 8 * k +: 8];
            inv = lswpg_pkg::SINE_FULL - {1'b0, w_reg[k]};
            mx  = is_mix ? cb : (is_rainbow ? 8'hFF : ca);
            prod_a = {17'b0, ca} * {8'b0, inv};
            prod_b = {17'b0, mx} * {9'b0, w_reg[k]};
            if (is_mix) begin
                pa_next[k] = prod_a[23:0];
                pb_next[k] = prod_b[23:0];
            end else if (is_chan || is_rainbow) begin
                pa_next[k] = 24'd0;
                pb_next[k] = prod_b[23:0];
            end else begin
                pa_next[k] = 24'd0;
                pb_next[k] = {ca, 16'd0};
            end

            sum = {1'b0, pa_reg[k]} + {1'b0, pb_reg[k]};
            sc_next[k] = 15'(sum[23:16]) * 15'(bval);

            qprod = 31'(sc_reg[k]) * 31'(lswpg_pkg::DIV100_MUL);
            q_next[k] = qprod[lswpg_pkg::DIV100_SHIFT +: 8];
        end
    end

    // Phase after the frame
    always_comb begin
        logic [9:0] fwd;
        logic [9:0] rev;
        logic       circling;
        logic       moving;
        fwd = {1'b0, phase_reg} + lswpg_pkg::PHASE_STEP;
        if (fwd >= lswpg_pkg::DEG_FULL) fwd = fwd - lswpg_pkg::DEG_FULL;
        rev = ({1'b0, phase_reg} < lswpg_pkg::PHASE_STEP)
              ? ({1'b0, phase_reg} + lswpg_pkg::DEG_FULL - lswpg_pkg::PHASE_STEP)
              : ({1'b0, phase_reg} - lswpg_pkg::PHASE_STEP);
        circling = (cfg.mode == lswpg_pkg::MODE_CIRCLE) || (cfg.mode == lswpg_pkg::MODE_CIRCLE2)
                   || (cfg.mode == lswpg_pkg::MODE_RB_WAVE)
                   || (cfg.mode == lswpg_pkg::MODE_RB_MUL_A)
                   || (cfg.mode == lswpg_pkg::MODE_RB_MUL_B);
        moving = step_reg && (is_mix || is_chan || is_rainbow);
        phase_next = phase_reg;
        if (moving) phase_next = (circling && cfg.reverse) ? rev[8:0] : fwd[8:0];
    end

    // Phase and LED position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 9'd0;
            step_reg    <= 1'b0;
            led_idx_reg <= 6'd0;
        end else begin
            if (cmd.load) begin
                step_reg    <= s_step;
                led_idx_reg <= 6'd0;
            end else if (cmd.advance) begin
                led_idx_reg <= led_idx_reg + 6'd1;
            end
            if (cmd.phase_upd) phase_reg <= phase_next;
        end
    end

    // Lane pipeline registers, free running between LED changes
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (cmd.load || cmd.advance) ang_reg[k] <= ang_next[k];
            w_reg[k]  <= w_next[k];
            pa_reg[k] <= pa_next[k];
            pb_reg[k] <= pb_next[k];
            sc_reg[k] <= sc_next[k];
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            out_idx_reg  <= led_idx_reg;
            out_last_reg <= st.last;
            for (int k = 0; k < 3; k++) begin
                out_chan_reg[k] <= q_next[k];
            end
        end
    end

    assign st.slot_free = !out_valid_reg || m_ready;
    assign st.last      = (led_idx_reg == LED_LAST);

    assign m_valid     = out_valid_reg;
    assign m_led_index = out_idx_reg;
    assign m_red       = out_chan_reg[0];
    assign m_green     = out_chan_reg[1];
    assign m_blue      = out_chan_reg[2];
    assign m_last      = out_last_reg;

    `LSWPG_ASSERT(a_phase_range, aclk, aresetn, phase_reg < 9'(lswpg_pkg::DEG_FULL), "phase out of range")
    `LSWPG_ASSERT(a_angle_range, aclk, aresetn, !(cmd.push) || (ang_reg[0] < 9'(lswpg_pkg::DEG_FULL) && ang_reg[1] < 9'(lswpg_pkg::DEG_FULL) && ang_reg[2] < 9'(lswpg_pkg::DEG_FULL)), "lane angle out of range")
    `LSWPG_ASSERT_NEXT(a_led_advance, aclk, aresetn, cmd.advance, led_idx_reg == $past(led_idx_reg) + 6'd1, "LED index did not advance by one")

endmodule

// File: src/led_strip_wave_pattern_generator_core.sv
// Each LED passes through sine lookup, products, brightness and divide by 100 in turn,
// and the sequencer starts the next LED only after the last one enters the result
// register; the next tick is taken in the cycle after the last LED enters the result
// register, later if the sink stalls.
// Reset: aresetn synchronous active low; phase to 0, registers to defaults.
// ----------------------------------------------------------------------------
// led_strip_wave_pattern_generator_core
// Top level: APB register file, frame sequencer and lane datapath.
// ----------------------------------------------------------------------------
module led_strip_wave_pattern_generator_core #(
    parameter int LED_COUNT = lswpg_pkg::LED_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tick request
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] step_phase, [7:1] zero
    // LED results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [5:0] led_index, [13:6] red,
                                                      // [21:14] green, [29:22] blue
    output logic                           m_tlast,   // last_led
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lswpg_pkg::PADDR_W-1:0]  paddr,
    input  logic [lswpg_pkg::PDATA_W-1:0]  pwdata,
    output logic [lswpg_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);

    logic [3:0]             mode_reg;
    logic [23:0]            colour_a_reg;
    logic [23:0]            colour_b_reg;
    logic [6:0]             brightness_reg;
    logic                   reverse_reg;
    logic                   wr_en;
    logic [2:0]             reg_idx;
    lswpg_pkg::cfg_t        cfg;
    lswpg_pkg::ctrl_cmd_t   cmd;
    lswpg_pkg::dp_status_t  st;
    logic [5:0]             led_index;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= lswpg_pkg::MODE_RST;
            colour_a_reg   <= lswpg_pkg::COLOUR_A_RST;
            colour_b_reg   <= lswpg_pkg::COLOUR_B_RST;
            brightness_reg <= lswpg_pkg::BRIGHTNESS_RST;
            reverse_reg    <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                lswpg_pkg::REG_MODE:       mode_reg       <= pwdata[3:0];
                lswpg_pkg::REG_COLOUR_A:   colour_a_reg   <= pwdata[23:0];
                lswpg_pkg::REG_COLOUR_B:   colour_b_reg   <= pwdata[23:0];
                lswpg_pkg::REG_BRIGHTNESS: brightness_reg <= pwdata[6:0];
                lswpg_pkg::REG_REVERSE:    reverse_reg    <= pwdata[0];
                default: mode_reg <= mode_reg;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            lswpg_pkg::REG_MODE:       prdata = {28'd0, mode_reg};
            lswpg_pkg::REG_COLOUR_A:   prdata = {8'd0, colour_a_reg};
            lswpg_pkg::REG_COLOUR_B:   prdata = {8'd0, colour_b_reg};
            lswpg_pkg::REG_BRIGHTNESS: prdata = {25'd0, brightness_reg};
            lswpg_pkg::REG_REVERSE:    prdata = {31'd0, reverse_reg};
            default:                   prdata = '0;
        endcase
    end

    assign cfg.mode       = mode_reg;
    assign cfg.colour_a   = colour_a_reg;
    assign cfg.colour_b   = colour_b_reg;
    assign cfg.brightness = brightness_reg;
    assign cfg.reverse    = reverse_reg;

    lswpg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lswpg_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .st          (st),
        .s_step      (s_tdata[0]),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_led_index (led_index),
        .m_red       (red),
        .m_green     (green),
        .m_blue      (blue),
        .m_last      (m_tlast)
    );

    // Pack result fields
    assign m_tdata = {2'b00, blue, green, red, led_index};

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED strip wave pattern generator core. Tick
// requests go in on the slave stream and the register file is set over APB.
// A frame predictor computes the colour of every LED. Each LED result taken
// from the master stream is checked against the oldest predicted one.
// Both streams idle at random, and one long sink stall fills the core.
// ----------------------------------------------------------------------------
module tb;

    localparam int LED_COUNT     = lswpg_pkg::LED_COUNT_DEF;
    localparam int FRAME_LEDS    = (LED_COUNT < 1) ? 1 : ((LED_COUNT > 64) ? 64 : LED_COUNT);
    localparam int CLK_HALF      = 5;
    localparam int IDLE_PCT      = 33;
    localparam int HOLD_CYCLES   = 300;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int SETTLE_CYCLES = 4 * FRAME_LEDS + 16;

    // Register slots past the last defined register
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // Mode codes with no pattern behind them
    localparam logic [3:0] MODE_UNDEF_LO = 4'd9;
    localparam logic [3:0] MODE_UNDEF_HI = 4'd15;

    // Angle steps in degrees and the full colour scale
    localparam int unsigned ANGLE_PER_LED = 24;
    localparam int unsigned RAINBOW_SHIFT = 120;
    localparam int unsigned FULL_SCALE    = 255;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_led;
    } led_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;
    logic                            m_tlast;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [lswpg_pkg::PADDR_W-1:0]   paddr;
    logic [lswpg_pkg::PDATA_W-1:0]   pwdata;
    logic [lswpg_pkg::PDATA_W-1:0]   prdata;
    logic                            pready;

    // Predicted register file and phase
    logic [3:0]  cfg_mode       = lswpg_pkg::MODE_RST;
    logic [23:0] cfg_colour_a   = lswpg_pkg::COLOUR_A_RST;
    logic [23:0] cfg_colour_b   = lswpg_pkg::COLOUR_B_RST;
    logic [6:0]  cfg_brightness = lswpg_pkg::BRIGHTNESS_RST;
    logic        cfg_reverse    = 1'b0;
    int unsigned wave_phase     = 0;

    led_result_t led_expect_q[$];
    int          mismatches  = 0;
    int          quiet_count = 0;
    bit          gaps_on     = 1'b1;
    bit          stalls_on   = 1'b1;
    bit          hold_req    = 1'b0;

    // Quarter-wave sine, unsigned Q0.15, 0..90 degrees
    int unsigned sine_q [0:90] = '{
        0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
        5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
        11207, 11743, 12275, 12803, 13328, 13848, 14364, 14876, 15383, 15886,
        16384, 16876, 17364, 17846, 18323, 18794, 19260, 19720, 20173, 20621,
        21062, 21497, 21925, 22347, 22762, 23170, 23571, 23964, 24351, 24730,
        25101, 25465, 25821, 26169, 26509, 26841, 27165, 27481, 27788, 28087,
        28377, 28659, 28932, 29196, 29451, 29697, 29934, 30162, 30381, 30591,
        30791, 30982, 31163, 31335, 31498, 31650, 31794, 31927, 32051, 32165,
        32269, 32364, 32448, 32523, 32587, 32642, 32687, 32722, 32747, 32762,
        32767
    };

    led_strip_wave_pattern_generator_core #(
        .LED_COUNT (LED_COUNT)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [0] step_phase, [7:1] zero
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [5:0] led_index, [13:6] red, [21:14] green, [29:22] blue
        .m_tlast  (m_tlast),    // last_led
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Free-running clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Weight 32768 + sine of the angle, taken mod 360
    function automatic int unsigned wave_weight(input int unsigned deg);
        int unsigned d;
        int unsigned q;
        bit          neg;
        d = deg % 360;
        if (d <= 90) begin
            q = sine_q[d];
            neg = 1'b0;
        end else if (d <= 180) begin
            q = sine_q[180 - d];
            neg = 1'b0;
        end else if (d <= 270) begin
            q = sine_q[d - 180];
            neg = 1'b1;
        end else begin
            q = sine_q[360 - d];
            neg = 1'b1;
        end
        return neg ? (32768 - q) : (32768 + q);
    endfunction

    function automatic int unsigned wave_scale(input int unsigned m, input int unsigned deg);
        return (m * wave_weight(deg)) >> 16;
    endfunction

    function automatic int unsigned wave_blend(input int unsigned a, input int unsigned b,
                                               input int unsigned deg);
        longint unsigned w;
        w = wave_weight(deg);
        return int'((a * (65536 - w) + b * w) >> 16);
    endfunction

    // Predict one frame of LED colours, then move the phase
    task automatic render_frame(input logic step);
        led_result_t r;
        int unsigned a;
        int unsigned b;
        int unsigned c;
        int unsigned mul;
        int unsigned bval;
        int unsigned p;
        int unsigned chans [3];
        bit          circling;
        p = wave_phase;
        bval = 32'((cfg_brightness > lswpg_pkg::BRIGHT_MAX)
                   ? (cfg_brightness - lswpg_pkg::BRIGHT_WRAP) : cfg_brightness);
        for (int i = 0; i < FRAME_LEDS; i++) begin
            for (int k = 0; k < 3; k++) begin
                a = 32'((cfg_colour_a >> (16 - 8 * k)) & 24'hFF);
                b = 32'((cfg_colour_b >> (16 - 8 * k)) & 24'hFF);
                case (cfg_mode)
                    lswpg_pkg::MODE_PULSE:    c = wave_scale(a, p);
                    lswpg_pkg::MODE_FADE:     c = wave_blend(a, b, p);
                    lswpg_pkg::MODE_CIRCLE:   c = wave_scale(a, p + ANGLE_PER_LED * i);
                    lswpg_pkg::MODE_CIRCLE2:  c = wave_blend(a, b, p + ANGLE_PER_LED * i);
                    lswpg_pkg::MODE_RB_SOLID: c = wave_scale(FULL_SCALE, p + RAINBOW_SHIFT * k);
                    lswpg_pkg::MODE_RB_WAVE: begin
                        c = wave_scale(FULL_SCALE, p + ANGLE_PER_LED * i + RAINBOW_SHIFT * k);
                    end
                    lswpg_pkg::MODE_RB_MUL_A: begin
                        mul = (k == 0) ? 6 : ((k == 1) ? 0 : 24);
                        c = wave_scale(FULL_SCALE, p + mul * i);
                    end
                    lswpg_pkg::MODE_RB_MUL_B: begin
                        mul = (k == 0) ? 2 : ((k == 1) ? 6 : 0);
                        c = wave_scale(FULL_SCALE, p + mul * i);
                    end
                    default: c = a;
                endcase
                chans[k] = ((c & 32'hFF) * bval) / 100;
            end
            r.led_index = i[5:0];
            r.red       = chans[0][7:0];
            r.green     = chans[1][7:0];
            r.blue      = chans[2][7:0];
            r.last_led  = (i == FRAME_LEDS - 1);
            led_expect_q.push_back(r);
        end

        // Advance phase for animated modes only
        if (step && cfg_mode >= lswpg_pkg::MODE_PULSE && cfg_mode <= lswpg_pkg::MODE_RB_MUL_B)
        begin
            circling = (cfg_mode == lswpg_pkg::MODE_CIRCLE)
                       || (cfg_mode == lswpg_pkg::MODE_CIRCLE2)
                       || (cfg_mode >= lswpg_pkg::MODE_RB_WAVE);
            if (circling && cfg_reverse) begin
                wave_phase = (wave_phase < 5) ? wave_phase + 355 : wave_phase - 5;
            end else begin
                wave_phase = wave_phase + 5;
                if (wave_phase >= 360) begin
                    wave_phase = wave_phase - 360;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Send one tick request; starts and ends at a falling edge
    task automatic send_tick(input logic step);
        if (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, step};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        render_frame(step);
        @(negedge aclk);
    endtask

    // Drop the request and wait for every predicted LED to come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (led_expect_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            lswpg_pkg::REG_MODE:       cfg_mode       = value[3:0];
            lswpg_pkg::REG_COLOUR_A:   cfg_colour_a   = value[23:0];
            lswpg_pkg::REG_COLOUR_B:   cfg_colour_b   = value[23:0];
            lswpg_pkg::REG_BRIGHTNESS: cfg_brightness = value[6:0];
            lswpg_pkg::REG_REVERSE:    cfg_reverse    = value[0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] idx, input logic [31:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want) begin
            report_mismatch($sformatf("register %0d read", idx), prdata, want);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random garbage above the register width
    function automatic logic [31:0] junk_above(input int width);
        return ($urandom() >> width) << width;
    endfunction

    // Both phase wraps: reverse below zero, then forward past 355
    task automatic test_phase_wrap();
        apb_write(lswpg_pkg::REG_MODE, 32'(lswpg_pkg::MODE_CIRCLE));
        apb_write(lswpg_pkg::REG_REVERSE, 32'd1);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_idle();
        apb_write(lswpg_pkg::REG_REVERSE, 32'd0);
        send_tick(1'b1);
        wait_idle();
    endtask

    // One stepping frame per mode, undefined codes included
    task automatic test_each_mode();
        apb_write(lswpg_pkg::REG_COLOUR_B, 32'h00_40A0E0);
        for (int m = lswpg_pkg::MODE_SOLID; m <= lswpg_pkg::MODE_RB_MUL_B; m++) begin
            wait_idle();
            apb_write(lswpg_pkg::REG_MODE, m);
            send_tick(1'b1);
        end
        wait_idle();
        apb_write(lswpg_pkg::REG_MODE, 32'(MODE_UNDEF_LO));
        send_tick(1'b1);
        wait_idle();
        apb_write(lswpg_pkg::REG_MODE, 32'(MODE_UNDEF_HI));
        send_tick(1'b1);
        wait_idle();
    endtask

    // Brightness limits, the wrap above 100, and colour extremes
    task automatic test_brightness_and_colours();
        logic [6:0] levels [4];
        levels = '{7'd0, lswpg_pkg::BRIGHT_MAX, lswpg_pkg::BRIGHT_WRAP, 7'h7F};
        apb_write(lswpg_pkg::REG_MODE, 32'(lswpg_pkg::MODE_FADE));
        foreach (levels[j]) begin
            apb_write(lswpg_pkg::REG_BRIGHTNESS, 32'(levels[j]));
            send_tick(1'b1);
            wait_idle();
        end
        apb_write(lswpg_pkg::REG_COLOUR_A, 32'h0);
        apb_write(lswpg_pkg::REG_COLOUR_B, 32'hFF_FFFFFF);
        send_tick(1'b0);
        wait_idle();
        apb_write(lswpg_pkg::REG_MODE, 32'(lswpg_pkg::MODE_PULSE));
        apb_write(lswpg_pkg::REG_COLOUR_A, 32'h00_FFFFFF);
        send_tick(1'b1);
        wait_idle();
    endtask

    // Write masking, spare addresses ignored, read back
    task automatic test_register_access();
        apb_write(lswpg_pkg::REG_MODE, junk_above(4) | 32'(lswpg_pkg::MODE_RB_WAVE));
        apb_write(lswpg_pkg::REG_COLOUR_A, junk_above(24) | $urandom_range(0, 24'hFFFFFF));
        apb_write(lswpg_pkg::REG_COLOUR_B, junk_above(24) | $urandom_range(0, 24'hFFFFFF));
        apb_write(lswpg_pkg::REG_BRIGHTNESS, junk_above(7) | $urandom_range(0, 100));
        apb_write(lswpg_pkg::REG_REVERSE, junk_above(1) | 32'd1);
        for (int r = REG_SPARE_LO; r <= REG_SPARE_HI; r++) begin
            apb_write(r[2:0], $urandom());
        end
        apb_read_check(lswpg_pkg::REG_MODE, {28'd0, cfg_mode});
        apb_read_check(lswpg_pkg::REG_COLOUR_A, {8'd0, cfg_colour_a});
        apb_read_check(lswpg_pkg::REG_COLOUR_B, {8'd0, cfg_colour_b});
        apb_read_check(lswpg_pkg::REG_BRIGHTNESS, {25'd0, cfg_brightness});
        apb_read_check(lswpg_pkg::REG_REVERSE, {31'd0, cfg_reverse});
        send_tick(1'b1);
        send_tick(1'b1);
        wait_idle();
    endtask

    // Stall the sink for a long stretch while ticks keep coming
    task automatic test_back_pressure();
        hold_req = 1'b1;
        repeat (6) send_tick(1'b1);
        while (hold_req) @(negedge aclk);
        wait_idle();
    endtask

    // Pick a random setting, biased toward animated modes and extremes
    task automatic random_settings();
        logic [6:0] levels [4];
        levels = '{7'd0, lswpg_pkg::BRIGHT_MAX, lswpg_pkg::BRIGHT_WRAP, 7'h7F};
        if ($urandom_range(0, 99) < 85) begin
            apb_write(lswpg_pkg::REG_MODE, junk_above(4)
                      | $urandom_range(32'(lswpg_pkg::MODE_PULSE),
                                       32'(lswpg_pkg::MODE_RB_MUL_B)));
        end else begin
            apb_write(lswpg_pkg::REG_MODE, junk_above(4) | $urandom_range(0, 15));
        end
        apb_write(lswpg_pkg::REG_COLOUR_A,
                  ($urandom_range(0, 9) == 0) ? 32'h00_FFFFFF : $urandom());
        apb_write(lswpg_pkg::REG_COLOUR_B, ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom());
        if ($urandom_range(0, 3) == 0) begin
            apb_write(lswpg_pkg::REG_BRIGHTNESS, 32'(levels[2'($urandom_range(0, 3))]));
        end else begin
            apb_write(lswpg_pkg::REG_BRIGHTNESS, $urandom());
        end
        apb_write(lswpg_pkg::REG_REVERSE, $urandom());
    endtask

    task automatic test_random_frames();
        for (int ph = 0; ph < 10; ph++) begin
            random_settings();
            repeat (45) send_tick($urandom_range(0, 99) < 80);
            wait_idle();
        end
    endtask

    // No idling on either side
    task automatic test_steady_stream();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        random_settings();
        repeat (30) send_tick($urandom_range(0, 99) < 80);
        wait_idle();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Sink: random stalls, plus a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= !stalls_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Check each LED result against the oldest prediction
    always @(posedge aclk) begin : check_leds
        led_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (led_expect_q.size() == 0) begin
                report_mismatch("LED result with no frame pending", m_tdata, 0);
            end else begin
                want = led_expect_q.pop_front();
                if (m_tdata[5:0] !== want.led_index) begin
                    report_mismatch("led_index", 32'(m_tdata[5:0]), 32'(want.led_index));
                end
                if (m_tdata[13:6] !== want.red) begin
                    report_mismatch("red", 32'(m_tdata[13:6]), 32'(want.red));
                end
                if (m_tdata[21:14] !== want.green) begin
                    report_mismatch("green", 32'(m_tdata[21:14]), 32'(want.green));
                end
                if (m_tdata[29:22] !== want.blue) begin
                    report_mismatch("blue", 32'(m_tdata[29:22]), 32'(want.blue));
                end
                if (m_tlast !== want.last_led) begin
                    report_mismatch("last_led", 32'(m_tlast), 32'(want.last_led));
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= WATCHDOG_MAX) begin
            $display("Timeout after %0d quiet cycles at %0t", quiet_count, $time);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        // Hold reset, then release it at a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_phase_wrap();
        test_each_mode();
        test_brightness_and_colours();
        test_register_access();
        test_back_pressure();
        test_random_frames();
        test_steady_stream();

        // Drain and let the core settle
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (led_expect_q.size() != 0) begin
            report_mismatch("LED results never delivered", 0, led_expect_q.size());
        end
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
